// File: src/qet_pkg.sv
// Shared types, constants and register indexes for the quadratic escape-time engine.
package qet_pkg;

   // Default widths of the iteration counter and of the fraction of all fixed-point values.
   localparam int COUNT_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 24;

   // Integer bits of the internal z format.
   localparam int ZINT_BITS = 24;

   // Configuration port geometry.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONST_RE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONST_IM  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ESC_RAD   = 3'd4;

   // Register widths.
   localparam int MAX_ITER_W = 16;
   localparam int ESC_RAD_W  = 13;
   localparam int RSQ_W      = 2 * ESC_RAD_W;
   localparam int ITER_W     = 16;

   // Mode codes.
   localparam logic MODE_JULIA      = 1'b0;
   localparam logic MODE_MANDELBROT = 1'b1;

   // Register values after reset.
   localparam logic                  MODE_RST     = MODE_MANDELBROT;
   localparam logic signed [31:0]    CONST_RE_RST = -32'sd16777216;
   localparam logic signed [31:0]    CONST_IM_RST = 32'sd0;
   localparam logic [MAX_ITER_W-1:0] MAX_ITER_RST = 16'd150;
   localparam logic [ESC_RAD_W-1:0]  ESC_RAD_RST  = 13'd1000;

   // Shift codes of the multiply-accumulate unit, in multiples of the half width.
   localparam logic [1:0] SHIFT_NONE = 2'd0;
   localparam logic [1:0] SHIFT_HALF = 2'd1;
   localparam logic [1:0] SHIFT_FULL = 2'd2;

   typedef struct packed {
      logic signed [31:0] point_re;
      logic signed [31:0] point_im;
   } req_type;

   typedef struct packed {
      logic [ITER_W-1:0] iterations;
      logic              escaped;
   } rsp_type;

   typedef struct packed {
      logic       en;
      logic       clr;
      logic [1:0] shift;
   } mac_ctl_type;

endpackage

// File: src/quadratic_escape_time.sv
// Top level of the quadratic escape-time engine (Mandelbrot and Julia iteration).
//
// Usage: a point (req_data.point_re, req_data.point_im, both Q8.24) is taken as an item at a
// clock edge where start is high and busy is low. The engine then iterates z = z*z + c with
// z held in Q24.24, until the squared modulus of z exceeds escape_radius squared, a new z
// component leaves the Q24.24 range (also an escape), or max_iterations steps are done.
// In Mandelbrot mode z starts at zero and c is the point; in Julia mode z starts at the
// point and c is the configured constant.
// The result item (iteration count and escaped flag) is shown on rsp_data for exactly one
// cycle with rsp_valid high; busy drops in that same cycle. The receiver cannot stall.
// Each complex step forms the three full products re*re, im*im and re*im on the single
// half-width multiplier, from twelve partial products; setup first squares the escape
// radius on the same multiplier. An item that ends because z left the Q24.24 range gives
// its result before the products of the new z are formed, and a zero limit gives it right
// after setup, with no product formed. A new item may start in the cycle the result is
// shown.
// Reset returns the engine to idle, drops any item in flight and restores the
// configuration registers (Mandelbrot mode, c = -1, limit 150, radius 1000).
// Configuration registers are written through csr_we, csr_index and csr_wdata; the user
// must write them only while idle, which the block itself does not enforce.
module quadratic_escape_time
   import qet_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // z is signed with ZINT_BITS integer bits; magnitudes are split into two halves.
   localparam int ZW    = ZINT_BITS + FRAC_BITS;
   localparam int HW    = (ZW + 1) / 2;
   localparam int AW    = 4 * HW;
   localparam int SQW   = 2 * ZW;
   localparam int DW    = 2 * ZW + 1;
   localparam int LW    = (COUNT_BITS > MAX_ITER_W) ? COUNT_BITS : MAX_ITER_W;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RSQ   = 3'd1;
   localparam logic [2:0] ST_RSQW  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_MFIN  = 3'd4;
   localparam logic [2:0] ST_STEP1 = 3'd5;
   localparam logic [2:0] ST_STEP2 = 3'd6;
   localparam logic [2:0] ST_NORM  = 3'd7;

   // Sub-step counts of the product phase: four partial products for each full product.
   localparam logic [3:0] MSUB_II   = 4'd4;
   localparam logic [3:0] MSUB_RI   = 4'd8;
   localparam logic [3:0] MSUB_LAST = 4'd11;

   // Configuration registers.
   logic                  mode_ff,     mode_in;
   logic signed [31:0]    const_re_ff, const_re_in;
   logic signed [31:0]    const_im_ff, const_im_in;
   logic [MAX_ITER_W-1:0] max_iter_ff, max_iter_in;
   logic [ESC_RAD_W-1:0]  esc_rad_ff,  esc_rad_in;

   // Sequencer and datapath registers.
   logic [2:0]            state_ff, state_in;
   logic [3:0]            msub_ff,  msub_in;
   logic                  first_ff, first_in;
   logic [COUNT_BITS-1:0] cnt_ff,   cnt_in;
   logic signed [ZW-1:0]  zr_ff,    zr_in;
   logic signed [ZW-1:0]  zi_ff,    zi_in;
   logic signed [31:0]    cr_ff,    cr_in;
   logic signed [31:0]    ci_ff,    ci_in;
   logic [RSQ_W-1:0]      rsq_ff,   rsq_in;
   logic [SQW-1:0]        rr_ff,    rr_in;
   logic [SQW-1:0]        ii_ff,    ii_in;
   logic [SQW-1:0]        ri_ff,    ri_in;
   logic signed [DW-1:0]  dr_ff,    dr_in;
   logic signed [DW-1:0]  di_ff,    di_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff,  rsp_data_in;

   // Shared multiplier.
   mac_ctl_type           mac_ctl;
   logic [HW-1:0]         mac_a;
   logic [HW-1:0]         mac_b;
   logic [AW-1:0]         acc;

   // Combinational helpers.
   logic [ZW-1:0]         zr_mag;
   logic [ZW-1:0]         zi_mag;
   logic [2*HW-1:0]       opa_full;
   logic [2*HW-1:0]       opb_full;
   logic [1:0]            part;
   logic [1:0]            prod_sel;
   logic [LW-1:0]         lim_ext;
   logic [LW-1:0]         cnt_max;
   logic [COUNT_BITS-1:0] limit;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic signed [DW-1:0]  nr;
   logic signed [DW-1:0]  ni;
   logic [DW-ZW:0]        nr_top;
   logic [DW-ZW:0]        ni_top;
   logic                  z_fits;
   logic [DW-1:0]         norm;
   logic [DW-1:0]         thr;

   qet_mac #(
      .HALF_W (HW)
   ) u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (acc)
   );

   // The iteration limit saturates at the largest count the counter can hold.
   assign lim_ext = LW'(max_iter_ff);
   assign cnt_max = LW'({COUNT_BITS{1'b1}});
   assign limit   = (lim_ext > cnt_max) ? COUNT_BITS'(cnt_max) : COUNT_BITS'(lim_ext);
   assign cnt_inc = cnt_ff + 1'b1;

   // Operand magnitudes; squares and the cross product are formed unsigned.
   assign zr_mag   = zr_ff[ZW-1] ? ZW'(-zr_ff) : ZW'(zr_ff);
   assign zi_mag   = zi_ff[ZW-1] ? ZW'(-zi_ff) : ZW'(zi_ff);
   assign part     = msub_ff[1:0];
   assign prod_sel = msub_ff[3:2];
   assign opa_full = (prod_sel == 2'd1) ? (2*HW)'(zi_mag) : (2*HW)'(zr_mag);
   assign opb_full = (prod_sel == 2'd0) ? (2*HW)'(zr_mag) : (2*HW)'(zi_mag);

   always_comb begin
      mac_ctl = '0;
      mac_a   = '0;
      mac_b   = '0;
      if (state_ff == ST_RSQ) begin
         mac_ctl.en  = 1'b1;
         mac_ctl.clr = 1'b1;
         mac_a       = HW'(esc_rad_ff);
         mac_b       = HW'(esc_rad_ff);
      end else if (state_ff == ST_MUL) begin
         mac_ctl.en    = 1'b1;
         mac_ctl.clr   = (part == 2'd0);
         mac_ctl.shift = {part[1] & part[0], part[1] ^ part[0]};
         mac_a         = part[1] ? opa_full[2*HW-1:HW] : opa_full[HW-1:0];
         mac_b         = part[0] ? opb_full[2*HW-1:HW] : opb_full[HW-1:0];
      end
   end

   // New z: the floor division by the fraction scale is an arithmetic shift.
   assign nr     = (dr_ff >>> FRAC_BITS) + DW'(cr_ff);
   assign ni     = (di_ff >>> (FRAC_BITS - 1)) + DW'(ci_ff);
   assign nr_top = nr[DW-1:ZW-1];
   assign ni_top = ni[DW-1:ZW-1];
   assign z_fits = ((&nr_top) | ~(|nr_top)) & ((&ni_top) | ~(|ni_top));

   // Squared modulus against R*R scaled to the product format.
   assign norm = DW'(rr_ff) + DW'(ii_ff);
   assign thr  = DW'(rsq_ff) << (2 * FRAC_BITS);

   // Configuration writes.
   always_comb begin
      mode_in     = mode_ff;
      const_re_in = const_re_ff;
      const_im_in = const_im_ff;
      max_iter_in = max_iter_ff;
      esc_rad_in  = esc_rad_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:     mode_in     = csr_wdata[0];
            CSR_CONST_RE: const_re_in = csr_wdata;
            CSR_CONST_IM: const_im_in = csr_wdata;
            CSR_MAX_ITER: max_iter_in = csr_wdata[MAX_ITER_W-1:0];
            CSR_ESC_RAD:  esc_rad_in  = csr_wdata[ESC_RAD_W-1:0];
            default:      ;
         endcase
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      msub_in      = msub_ff;
      first_in     = first_ff;
      cnt_in       = cnt_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      rsq_in       = rsq_ff;
      rr_in        = rr_ff;
      ii_in        = ii_ff;
      ri_in        = ri_ff;
      dr_in        = dr_ff;
      di_in        = di_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (mode_ff == MODE_MANDELBROT) begin
                  zr_in = '0;
                  zi_in = '0;
                  cr_in = req_data.point_re;
                  ci_in = req_data.point_im;
               end else begin
                  zr_in = ZW'(req_data.point_re);
                  zi_in = ZW'(req_data.point_im);
                  cr_in = const_re_ff;
                  ci_in = const_im_ff;
               end
               cnt_in   = '0;
               first_in = 1'b1;
               state_in = ST_RSQ;
            end
         end
         ST_RSQ: begin
            state_in = ST_RSQW;
         end
         ST_RSQW: begin
            rsq_in = acc[RSQ_W-1:0];
            if (limit == '0) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.iterations = '0;
               rsp_data_in.escaped    = 1'b0;
               state_in               = ST_IDLE;
            end else begin
               msub_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // The accumulator holds the previous full product when a new one opens.
            if (msub_ff == MSUB_II) begin
               rr_in = acc[SQW-1:0];
            end
            if (msub_ff == MSUB_RI) begin
               ii_in = acc[SQW-1:0];
            end
            if (msub_ff == MSUB_LAST) begin
               state_in = ST_MFIN;
            end else begin
               msub_in = msub_ff + 1'b1;
            end
         end
         ST_MFIN: begin
            ri_in = acc[SQW-1:0];
            if (first_ff) begin
               first_in = 1'b0;
               state_in = ST_STEP1;
            end else begin
               state_in = ST_NORM;
            end
         end
         ST_STEP1: begin
            dr_in = DW'(rr_ff) - DW'(ii_ff);
            di_in = (zr_ff[ZW-1] ^ zi_ff[ZW-1]) ? -DW'(ri_ff) : DW'(ri_ff);
            state_in = ST_STEP2;
         end
         ST_STEP2: begin
            if (!z_fits) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.iterations = ITER_W'(cnt_ff);
               rsp_data_in.escaped    = 1'b1;
               state_in               = ST_IDLE;
            end else begin
               zr_in    = nr[ZW-1:0];
               zi_in    = ni[ZW-1:0];
               msub_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_NORM: begin
            if (norm > thr) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.iterations = ITER_W'(cnt_ff);
               rsp_data_in.escaped    = 1'b1;
               state_in               = ST_IDLE;
            end else if (cnt_inc == limit) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.iterations = ITER_W'(cnt_inc);
               rsp_data_in.escaped    = 1'b0;
               state_in               = ST_IDLE;
            end else begin
               // The squares of the new z are already in place for the next step.
               cnt_in   = cnt_inc;
               state_in = ST_STEP1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_RST;
         const_re_ff  <= CONST_RE_RST;
         const_im_ff  <= CONST_IM_RST;
         max_iter_ff  <= MAX_ITER_RST;
         esc_rad_ff   <= ESC_RAD_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         const_re_ff  <= const_re_in;
         const_im_ff  <= const_im_in;
         max_iter_ff  <= max_iter_in;
         esc_rad_ff   <= esc_rad_in;
      end
      msub_ff     <= msub_in;
      first_ff    <= first_in;
      cnt_ff      <= cnt_in;
      zr_ff       <= zr_in;
      zi_ff       <= zi_in;
      cr_ff       <= cr_in;
      ci_ff       <= ci_in;
      rsq_ff      <= rsq_in;
      rr_ff       <= rr_in;
      ii_ff       <= ii_in;
      ri_ff       <= ri_in;
      dr_ff       <= dr_in;
      di_ff       <= di_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Every finished item produces its result in the cycle the engine goes idle.
   a_done_gives_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("engine went idle without a result");

   // A result is only shown while the engine is idle.
   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // A result always follows an item in work.
   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without an item in work");

endmodule

// File: src/qet_mac.sv
// Shared multiply-accumulate unit: one half-width product a cycle while enabled, shifted into an accumulator.
module qet_mac
   import qet_pkg::*;
#(
   parameter int HALF_W = 24
) (
   input  logic                  clock,
   input  mac_ctl_type           ctl,
   input  logic [HALF_W-1:0]     op_a,
   input  logic [HALF_W-1:0]     op_b,
   output logic [4*HALF_W-1:0]   acc
);

   localparam int ACC_W = 4 * HALF_W;

   logic [ACC_W-1:0]    acc_ff;
   logic [ACC_W-1:0]    acc_in;
   logic [2*HALF_W-1:0] prod;
   logic [ACC_W-1:0]    prod_sh;

   assign prod = (2*HALF_W)'(op_a) * (2*HALF_W)'(op_b);

   always_comb begin
      unique case (ctl.shift)
         SHIFT_NONE: prod_sh = ACC_W'(prod);
         SHIFT_HALF: prod_sh = ACC_W'(prod) << HALF_W;
         SHIFT_FULL: prod_sh = ACC_W'(prod) << (2 * HALF_W);
         default:    prod_sh = '0;
      endcase
      acc_in = acc_ff;
      if (ctl.en) begin
         acc_in = (ctl.clr ? '0 : acc_ff) + prod_sh;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// File: tb/quadratic_escape_time_tb.sv
// Self-checking testbench for the quadratic escape-time engine: directed table, then random phases.
`timescale 1ns / 1ps

module quadratic_escape_time_tb
   import qet_pkg::*;
();

   // Fixed-point geometry of the engine in its default build.
   localparam int FRAC  = FRAC_BITS_DEF;
   localparam int Z_MSB = ZINT_BITS + FRAC_BITS_DEF - 1;

   // Handy Q8.24 values for the directed part.
   localparam logic [31:0] ONE       = 32'h0100_0000;
   localparam logic [31:0] TWO       = 32'h0200_0000;
   localparam logic [31:0] MINUS_TWO = 32'hFE00_0000;
   localparam logic [31:0] SIXTY     = 32'h3C00_0000;
   localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_MAX   = 32'h8000_0000;

   // Random coordinates mostly fall in the box of +/-2.5 around the origin, where the
   // orbits are long and interesting. This is the half width of that box in Q8.24.
   localparam logic [31:0] REGION_SPAN = 32'd41943040;

   // An index that maps to no register; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd5;

   localparam int RANDOM_ITEMS = 1700;
   // The slowest item runs 150 steps.
   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 64;

   typedef enum logic [1:0] {ROW_WRITE, ROW_POINT, ROW_CHECKED} row_kind_type;

   // One row of the directed table: either a register write, or an item whose result is
   // predicted, or an item whose result is typed in by hand.
   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [31:0]           value;
      req_type               point;
      rsp_type               known;
   } plan_row_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_MODE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Our own copy of the configuration registers, kept in step with every write.
   logic                     cfg_mode     = MODE_RST;
   logic signed [31:0]       cfg_const_re = CONST_RE_RST;
   logic signed [31:0]       cfg_const_im = CONST_IM_RST;
   logic [MAX_ITER_W-1:0]    cfg_limit    = MAX_ITER_RST;
   logic [ESC_RAD_W-1:0]     cfg_radius   = ESC_RAD_RST;

   // Predicted results of accepted items, oldest first.
   rsp_type pending_escapes[$];
   rsp_type want;
   int      fails        = 0;
   int      quiet_cycles = 0;

   quadratic_escape_time u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // True when a value fits the signed Q24.24 format of z.
   function automatic logic fits_z(input logic signed [127:0] v);
      return (&v[127:Z_MSB]) || !(|v[127:Z_MSB]);
   endfunction

   // Iterates one point under the current configuration and returns the step count and
   // the escape flag. All products are kept exact in 128 bits; the arithmetic shifts give
   // the rounding toward minus infinity that the engine uses.
   function automatic rsp_type escape_time(input req_type p);
      logic signed [127:0] zr, zi, cr, ci;
      logic signed [127:0] sq_re, sq_im, prod_ri, nxt_re, nxt_im, bound;
      logic [MAX_ITER_W-1:0] steps;
      logic                  gone;
      rsp_type               r;
      if (cfg_mode == MODE_MANDELBROT) begin
         zr = '0;
         zi = '0;
         cr = $signed(p.point_re);
         ci = $signed(p.point_im);
      end else begin
         zr = $signed(p.point_re);
         zi = $signed(p.point_im);
         cr = cfg_const_re;
         ci = cfg_const_im;
      end
      // The escape threshold is R squared, scaled to the square of the z format.
      bound = 128'(cfg_radius);
      bound = (bound * bound) <<< (2 * FRAC);
      steps = '0;
      gone  = 1'b0;
      while (!gone && steps < cfg_limit) begin
         sq_re   = zr * zr;
         sq_im   = zi * zi;
         prod_ri = zr * zi;
         nxt_re  = ((sq_re - sq_im) >>> FRAC) + cr;
         nxt_im  = (prod_ri >>> (FRAC - 1)) + ci;
         // A component that leaves the z format counts as an escape at this step.
         if (!fits_z(nxt_re) || !fits_z(nxt_im)) begin
            gone = 1'b1;
         end else begin
            zr   = nxt_re;
            zi   = nxt_im;
            gone = (zr * zr + zi * zi) > bound;
         end
         if (!gone) steps++;
      end
      r.iterations = steps;
      r.escaped    = gone;
      return r;
   endfunction

   function automatic logic [31:0] pick_coord();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 78) begin
         return $urandom_range(0, 2 * REGION_SPAN) - REGION_SPAN;
      end else if (roll < 94) begin
         return $urandom();
      end
      case ($urandom_range(0, 3))
         0: return POS_MAX;
         1: return NEG_MAX;
         2: return '0;
         default: return ONE;
      endcase
   endfunction

   function automatic plan_row_type write_row(input logic [CSR_IDX_W-1:0] index,
                                              input logic [31:0] value);
      plan_row_type r;
      r       = '0;
      r.kind  = ROW_WRITE;
      r.index = index;
      r.value = value;
      return r;
   endfunction

   function automatic plan_row_type point_row(input logic [31:0] re, input logic [31:0] im);
      plan_row_type r;
      r                = '0;
      r.kind           = ROW_POINT;
      r.point.point_re = re;
      r.point.point_im = im;
      return r;
   endfunction

   function automatic plan_row_type checked_row(input logic [31:0] re, input logic [31:0] im,
                                                input logic [ITER_W-1:0] iters,
                                                input logic esc);
      plan_row_type r;
      r                  = point_row(re, im);
      r.kind             = ROW_CHECKED;
      r.known.iterations = iters;
      r.known.escaped    = esc;
      return r;
   endfunction

   // Offers one item and returns at the edge where it is taken. Start is left high so that
   // the next item can follow without a gap; the write enable is dropped here.
   task automatic send_point(input req_type p, input rsp_type expected);
      req_data <= p;
      start    <= 1'b1;
      csr_we   <= 1'b0;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      pending_escapes.push_back(expected);
   endtask

   // Writes one register. The write enable stays high until the next item is offered,
   // so back-to-back writes never drop and raise it within one time step.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_MODE:     cfg_mode     = value[0];
         CSR_CONST_RE: cfg_const_re = value;
         CSR_CONST_IM: cfg_const_im = value;
         CSR_MAX_ITER: cfg_limit    = value[MAX_ITER_W-1:0];
         CSR_ESC_RAD:  cfg_radius   = value[ESC_RAD_W-1:0];
         default: ;
      endcase
   endtask

   // Stops offering items and waits until every predicted result has come back. Each item
   // gives exactly one result, so the engine is idle once the queue is empty.
   task automatic settle();
      if (start) begin
         start <= 1'b0;
         @(posedge clock);
      end
      while (pending_escapes.size() != 0) @(posedge clock);
   endtask

   initial begin
      plan_row_type plan[$];
      req_type      point;
      int unsigned  sent, k, roll, phase_len, burst_left, gap;
      logic [MAX_ITER_W-1:0] limit;
      logic [ESC_RAD_W-1:0]  radius;

      // Reset configuration: Mandelbrot, limit 150, radius 1000. The origin and -2 both
      // stay bounded forever, so they run to the limit.
      plan.push_back(checked_row('0, '0, 16'd150, 1'b0));
      plan.push_back(checked_row(MINUS_TWO, '0, 16'd150, 1'b0));
      plan.push_back(point_row(TWO, '0));
      plan.push_back(point_row(POS_MAX, POS_MAX));
      plan.push_back(point_row(NEG_MAX, NEG_MAX));
      plan.push_back(point_row(NEG_MAX, POS_MAX));
      plan.push_back(point_row(32'h0040_0000, 32'h0080_0000));
      // A zero limit gives zero steps and no escape.
      plan.push_back(write_row(CSR_MAX_ITER, '0));
      plan.push_back(checked_row(ONE, ONE, 16'd0, 1'b0));
      plan.push_back(write_row(CSR_MAX_ITER, 32'd1));
      plan.push_back(checked_row('0, '0, 16'd1, 1'b0));
      // A zero radius makes any nonzero z escape at once.
      plan.push_back(write_row(CSR_ESC_RAD, '0));
      plan.push_back(checked_row(ONE, '0, 16'd0, 1'b1));
      plan.push_back(checked_row('0, '0, 16'd1, 1'b0));
      // The largest radius lets z grow until a new component leaves the z format, which must
      // also count as an escape. The largest limit is safe here since these points leave.
      plan.push_back(write_row(CSR_ESC_RAD, 32'd8191));
      plan.push_back(write_row(CSR_MAX_ITER, 32'd65535));
      plan.push_back(point_row(SIXTY, '0));
      plan.push_back(point_row(POS_MAX, NEG_MAX));
      plan.push_back(point_row('0, SIXTY));
      // Julia mode with the reset constant -1: the origin cycles between 0 and -1.
      plan.push_back(write_row(CSR_MODE, {31'd0, MODE_JULIA}));
      plan.push_back(write_row(CSR_MAX_ITER, 32'd20));
      plan.push_back(write_row(CSR_ESC_RAD, 32'd2));
      plan.push_back(checked_row('0, '0, 16'd20, 1'b0));
      plan.push_back(checked_row(POS_MAX, POS_MAX, 16'd0, 1'b1));
      plan.push_back(checked_row(NEG_MAX, NEG_MAX, 16'd0, 1'b1));
      // Extreme constants throw the origin far out on the first step.
      plan.push_back(write_row(CSR_CONST_RE, POS_MAX));
      plan.push_back(write_row(CSR_CONST_IM, NEG_MAX));
      plan.push_back(checked_row('0, '0, 16'd0, 1'b1));
      plan.push_back(write_row(CSR_CONST_RE, NEG_MAX));
      plan.push_back(write_row(CSR_CONST_IM, POS_MAX));
      plan.push_back(checked_row('0, '0, 16'd0, 1'b1));
      // A classic Julia constant near 0.285 + 0.01i.
      plan.push_back(write_row(CSR_CONST_RE, 32'h0048_F5C3));
      plan.push_back(write_row(CSR_CONST_IM, 32'h0002_8F5C));
      plan.push_back(point_row('0, '0));
      plan.push_back(point_row(32'h0080_0000, 32'hFF80_0000));
      // A write to an unmapped index must leave every register as it was.
      plan.push_back(write_row(CSR_UNUSED, 32'hFFFF_FFFF));
      plan.push_back(point_row('0, '0));
      // Back to Mandelbrot with junk in the unused upper data bits of each write.
      plan.push_back(write_row(CSR_MODE, 32'hFFFF_FFFF));
      plan.push_back(write_row(CSR_MAX_ITER, 32'hABCD_0040));
      plan.push_back(write_row(CSR_ESC_RAD, 32'hFFFF_E002));
      plan.push_back(point_row(32'hFF40_0000, 32'h0019_999A));
      plan.push_back(point_row(32'h0060_0000, 32'h0060_0000));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: items go back to back; before a write the engine is drained.
      foreach (plan[row]) begin
         case (plan[row].kind)
            ROW_WRITE: begin
               settle();
               write_reg(plan[row].index, plan[row].value);
            end
            ROW_POINT: send_point(plan[row].point, escape_time(plan[row].point));
            default: send_point(plan[row].point, plan[row].known);
         endcase
      end

      // Random part: a run of phases, each with a fresh configuration written while idle.
      // Most phases use short limits to keep the run short; a few use up to 150 steps.
      sent       = 0;
      burst_left = 1;
      while (sent < RANDOM_ITEMS) begin
         settle();
         roll = $urandom_range(0, 99);
         if (roll < 65) begin
            limit = MAX_ITER_W'($urandom_range(1, 24));
         end else if (roll < 88) begin
            limit = MAX_ITER_W'($urandom_range(25, 64));
         end else if (roll < 97) begin
            limit = MAX_ITER_W'($urandom_range(65, 150));
         end else begin
            limit = '0;
         end
         roll = $urandom_range(0, 99);
         if (roll < 50) begin
            radius = 13'd2;
         end else if (roll < 75) begin
            radius = ESC_RAD_W'($urandom_range(1, 16));
         end else if (roll < 85) begin
            radius = ESC_RAD_W'($urandom_range(17, 4096));
         end else if (roll < 95) begin
            radius = ESC_RAD_W'($urandom_range(4097, 8191));
         end else begin
            radius = '0;
         end
         if ($urandom_range(0, 1) == 1) write_reg(CSR_MODE, $urandom());
         if ($urandom_range(0, 1) == 1) write_reg(CSR_CONST_RE, pick_coord());
         if ($urandom_range(0, 1) == 1) write_reg(CSR_CONST_IM, pick_coord());
         if ($urandom_range(0, 7) == 0) write_reg(CSR_UNUSED, $urandom());
         write_reg(CSR_MAX_ITER, {16'($urandom()), limit});
         write_reg(CSR_ESC_RAD, {19'($urandom()), radius});

         phase_len = (limit > 64) ? 25 : 110;
         for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
            point.point_re = pick_coord();
            point.point_im = pick_coord();
            send_point(point, escape_time(point));
            sent++;
            // The sender works in bursts. Gaps of random length land the next start at
            // different points of the engine's iteration; a few bursts run long.
            burst_left--;
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 8);
               gap = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 400)
                                                 : $urandom_range(1, 40);
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end

      // Wait for the last results, then a little longer to catch any stray ones.
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fails == 0) begin
         $display("[quadratic_escape_time] OK");
      end else begin
         $display("[quadratic_escape_time] ERROR");
      end
      $finish;
   end

   // Result checker and watchdog. Results cannot be held off, so every strobe is taken
   // and compared with the oldest prediction. The watchdog ends the run when neither an
   // item nor a result has moved for too long.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_escapes.size() == 0) begin
            $error("result with no item outstanding: iterations %0d, escaped %0b",
                   rsp_data.iterations, rsp_data.escaped);
            fails++;
         end else begin
            want = pending_escapes.pop_front();
            if (rsp_data.iterations !== want.iterations) begin
               $error("iterations: expected %0d, got %0d", want.iterations,
                      rsp_data.iterations);
               fails++;
            end
            if (rsp_data.escaped !== want.escaped) begin
               $error("escaped: expected %0b, got %0b", want.escaped, rsp_data.escaped);
               fails++;
            end
         end
      end
      if (!reset && (rsp_valid === 1'b1 || (start && busy === 1'b0))) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[quadratic_escape_time] ERROR");
         $finish;
      end
   end

endmodule

// File: sim.f
src/qet_pkg.sv
src/qet_mac.sv
src/quadratic_escape_time.sv
tb/quadratic_escape_time_tb.sv
